[src/dtds_pkg.sv]
// ----------------------------------------------------------------------------
// dtds_pkg
// Shared widths, codes and bundle types of the task-graph dependency
// scoreboard.
// ----------------------------------------------------------------------------
package dtds_pkg;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 2;
    localparam int NODE_W   = 4;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 8;
    localparam int PREC_W   = 49;

    // Configuration register map
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = PREC_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_NODE_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRECEDENCE = 1'd1;
    localparam logic [NODE_W-1:0]     NODE_COUNT_RST = 4'd7;

    // Stream widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_NEW_JOB = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FINISH  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLAIM   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CHECK   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PENDING  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLAIMED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ARGS = 2'd3;

    typedef struct packed {
        logic [NODE_W-1:0] node_count;
        logic [PREC_W-1:0] precedence_bits;
    } cfg_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   job_slot;
        logic [NODE_W-1:0]   node;
    } req_t;

    typedef struct packed {
        logic                granted;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [MASK_W-1:0]   done_mask;
        logic [MASK_W-1:0]   claimed_mask;
    } rsp_t;

endpackage

[src/dtds_cfg.sv]
// ----------------------------------------------------------------------------
// dtds_cfg
// Configuration registers: node count and precedence matrix.
// ----------------------------------------------------------------------------
module dtds_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [dtds_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [dtds_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output dtds_pkg::cfg_t                    cfg
);
    import dtds_pkg::*;

    logic [NODE_W-1:0] node_count_reg;
    logic [PREC_W-1:0] precedence_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RST;
            precedence_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_NODE_COUNT: node_count_reg <= cfg_wdata[NODE_W-1:0];
                CFG_PRECEDENCE: precedence_reg <= cfg_wdata[PREC_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.node_count      = node_count_reg;
    assign cfg.precedence_bits = precedence_reg;

endmodule

[src/dtds_core.sv]
// ----------------------------------------------------------------------------
// dtds_core
// Job-slot ring with done/claimed masks; evaluates one request per cycle
// and commits its state change when the request advances.
// ----------------------------------------------------------------------------
module dtds_core #(
    parameter int QUEUE_DEPTH = 4,
    parameter int MAX_NODES   = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  dtds_pkg::req_t req,
    input  dtds_pkg::cfg_t cfg,
    output dtds_pkg::rsp_t rsp
);
    import dtds_pkg::*;

    localparam int NS_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [NS_W-1:0]   LAST_SLOT = NS_W'(QUEUE_DEPTH - 1);
    localparam logic [NODE_W-1:0] MAX_N     = NODE_W'(MAX_NODES);
    localparam logic [NODE_W-1:0] MIN_N     = NODE_W'(2);

    logic [MASK_W-1:0] done_reg  [QUEUE_DEPTH];
    logic [MASK_W-1:0] claim_reg [QUEUE_DEPTH];
    logic [NS_W-1:0]   newest_reg;
    logic              started_reg;

    logic [NS_W-1:0]   newest_next;
    logic [NS_W-1:0]   slot_idx;
    logic [NODE_W-1:0] n_eff;
    logic [MASK_W-1:0] cur_done;
    logic [MASK_W-1:0] cur_claim;
    logic [MASK_W-1:0] node_bit;
    logic [MASK_W-1:0] need_mask;
    logic              slot_ok;
    logic              node_ok;
    logic              ready;
    logic              wr_new;
    logic              wr_done;
    logic              wr_claim;

    // Predecessor mask of a node from the precedence matrix
    function automatic logic [MASK_W-1:0] preds_of(
        input logic [NODE_W-1:0] nd,
        input logic [NODE_W-1:0] n,
        input logic [PREC_W-1:0] prec
    );
        logic [MASK_W-1:0] m;
        logic [7:0]        base;
        logic [7:0]        idx;
        m    = '0;
        base = 8'(nd - NODE_W'(2)) * 8'(n - NODE_W'(1));
        for (int c = 0; c < MAX_NODES - 1; c++) begin
            idx = base + 8'(c);
            if ((NODE_W'(c + 1) < n) && (idx < 8'(PREC_W)))
                m[c] = prec[idx[5:0]];
        end
        return m;
    endfunction

    // Effective node count, saturated into the supported range
    always_comb begin
        if (cfg.node_count < MIN_N)
            n_eff = MIN_N;
        else if (cfg.node_count > MAX_N)
            n_eff = MAX_N;
        else
            n_eff = cfg.node_count;
    end

    // Ring pointer for the next new job
    assign newest_next = (!started_reg || newest_reg == LAST_SLOT) ? '0
                                                                   : newest_reg + NS_W'(1);

    // Slot lookup and readiness
    assign slot_ok   = (32'(req.job_slot) < QUEUE_DEPTH);
    assign slot_idx  = NS_W'(req.job_slot);
    assign cur_done  = slot_ok ? done_reg[slot_idx]  : '0;
    assign cur_claim = slot_ok ? claim_reg[slot_idx] : '0;
    assign node_ok   = (req.node != '0) && (req.node <= n_eff);
    assign node_bit  = MASK_W'(1) << (req.node - NODE_W'(1));
    assign need_mask = preds_of(req.node, n_eff, cfg.precedence_bits);
    assign ready     = (req.node <= NODE_W'(1)) || ((need_mask & ~cur_done) == '0);

    // Result and write enables
    always_comb begin
        rsp.granted      = 1'b0;
        rsp.status       = ST_OK;
        rsp.slot_out     = req.job_slot;
        rsp.done_mask    = cur_done;
        rsp.claimed_mask = cur_claim;
        wr_new   = 1'b0;
        wr_done  = 1'b0;
        wr_claim = 1'b0;
        if (req.action == ACT_NEW_JOB) begin
            wr_new           = 1'b1;
            rsp.granted      = 1'b1;
            rsp.slot_out     = SLOT_W'(newest_next);
            rsp.done_mask    = '0;
            rsp.claimed_mask = '0;
        end else if (!slot_ok || !node_ok) begin
            rsp.status = ST_BAD_ARGS;
        end else begin
            unique case (req.action)
                ACT_FINISH: begin
                    wr_done       = 1'b1;
                    rsp.granted   = 1'b1;
                    rsp.done_mask = cur_done | node_bit;
                end
                ACT_CLAIM: begin
                    if (!ready) begin
                        rsp.status = ST_PENDING;
                    end else if ((cur_claim & node_bit) != '0) begin
                        rsp.status = ST_CLAIMED;
                    end else begin
                        wr_claim         = 1'b1;
                        rsp.granted      = 1'b1;
                        rsp.claimed_mask = cur_claim | node_bit;
                    end
                end
                default: begin
                    rsp.granted = ready;
                    rsp.status  = ready ? ST_OK : ST_PENDING;
                end
            endcase
        end
    end

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                done_reg[i]  <= '0;
                claim_reg[i] <= '0;
            end
            newest_reg  <= '0;
            started_reg <= 1'b0;
        end else if (advance) begin
            if (wr_new) begin
                newest_reg            <= newest_next;
                started_reg           <= 1'b1;
                done_reg[newest_next]  <= '0;
                claim_reg[newest_next] <= '0;
            end
            if (wr_done)
                done_reg[slot_idx] <= rsp.done_mask;
            if (wr_claim)
                claim_reg[slot_idx] <= rsp.claimed_mask;
        end
    end

endmodule

[src/dag_task_dependency_scoreboard.sv]
// ----------------------------------------------------------------------------
// dag_task_dependency_scoreboard
// Task-graph dependency scoreboard over a ring of job slots.
// ----------------------------------------------------------------------------
// A request enters the input register when s_tready is high, is evaluated
// against the slot table and is captured in the result register when no held
// result blocks it. Throughput is one item per cycle while the receiver does
// not stall, set by the single evaluate-and-update pass of the slot table
// between those registers. Each request is checked against the slot state
// left by the request before it. Configuration writes take effect on the
// next cycle and are expected only while no request is in flight.
// ----------------------------------------------------------------------------
module dag_task_dependency_scoreboard #(
    parameter int QUEUE_DEPTH = 4,
    parameter int MAX_NODES   = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [dtds_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [dtds_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: [1:0] action, [3:2] job_slot, [7:4] node
    input  logic [dtds_pkg::IN_DATA_W-1:0]    s_tdata,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: [0] granted, [2:1] status, [4:3] slot_out, [12:5] done_mask,
    //        [20:13] claimed_mask, [23:21] zero
    output logic [dtds_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import dtds_pkg::*;

    cfg_t cfg;
    req_t req_reg;
    rsp_t rsp;
    rsp_t rsp_reg;
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;

    dtds_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dtds_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_NODES   (MAX_NODES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .req     (req_reg),
        .cfg     (cfg),
        .rsp     (rsp)
    );

    // Handshake: a request moves on when the result register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            req_reg.action   <= s_tdata[1:0];
            req_reg.job_slot <= s_tdata[3:2];
            req_reg.node     <= s_tdata[7:4];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rsp_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, rsp_reg.claimed_mask, rsp_reg.done_mask,
                       rsp_reg.slot_out, rsp_reg.status, rsp_reg.granted};

endmodule

[test/dag_task_dependency_scoreboard_tb.sv]
// ----------------------------------------------------------------------------
// dag_task_dependency_scoreboard_tb
// Drives request transfers into the scoreboard and checks every result
// transfer against a cycle-free model of the slot ring: new jobs, finishes,
// claims and readiness checks under several node counts and precedence
// graphs. Sender gaps and receiver stalls are inserted at random.
// ----------------------------------------------------------------------------
module dag_task_dependency_scoreboard_tb;
    import dtds_pkg::*;

    localparam int SLOTS         = 4;
    localparam int NODES         = 8;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 210;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_LIMIT   = 50;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    dag_task_dependency_scoreboard #(
        .QUEUE_DEPTH(SLOTS),
        .MAX_NODES  (NODES)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Model of the slot ring and its configuration
    logic [MASK_W-1:0] done_tbl  [SLOTS];
    logic [MASK_W-1:0] claim_tbl [SLOTS];
    logic [SLOT_W-1:0] ring_head;
    logic              ring_live;
    logic [NODE_W-1:0] cfg_nodes;
    logic [PREC_W-1:0] cfg_prec;

    // Slot the stimulus generator believes is newest
    logic [SLOT_W-1:0] gen_head;

    req_t request_q[$];
    rsp_t predicted_results[$];
    int   fail_count;
    int   send_idle_pct;
    int   recv_stall_pct;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run ends here if the traffic stalls
    initial begin
        #5000000;
        $display("dag_task_dependency_scoreboard_tb: FAIL");
        $finish;
    end

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Node count in use, saturated into 2..NODES
    function automatic int node_limit();
        if (cfg_nodes < 2) return 2;
        if (cfg_nodes > NODES) return NODES;
        return int'(cfg_nodes);
    endfunction

    function automatic bit preds_met(logic [NODE_W-1:0] node, logic [MASK_W-1:0] done);
        int n;
        int base;
        n = node_limit();
        if (node <= 1) return 1'b1;
        base = (int'(node) - 2) * (n - 1);
        for (int c = 0; c < n - 1; c++) begin
            if (base + c < PREC_W && cfg_prec[base + c] && !done[c]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one request to the model and returns the result it gives
    function automatic rsp_t score_request(req_t r);
        rsp_t              o;
        logic [MASK_W-1:0] node_bit;
        bit                ready;
        o          = '0;
        o.slot_out = r.job_slot;
        if (r.action == ACT_NEW_JOB) begin
            if (!ring_live || ring_head == SLOT_W'(SLOTS - 1)) ring_head = '0;
            else ring_head = ring_head + 1'b1;
            ring_live            = 1'b1;
            done_tbl[ring_head]  = '0;
            claim_tbl[ring_head] = '0;
            o.granted  = 1'b1;
            o.status   = ST_OK;
            o.slot_out = ring_head;
            return o;
        end
        // job_slot spans exactly the ring, so only the node can be out of range
        if (r.node == 0 || r.node > node_limit()) begin
            o.status = ST_BAD_ARGS;
        end else begin
            node_bit = MASK_W'(1) << (r.node - 1);
            ready    = preds_met(r.node, done_tbl[r.job_slot]);
            case (r.action)
                ACT_FINISH: begin
                    done_tbl[r.job_slot] = done_tbl[r.job_slot] | node_bit;
                    o.granted = 1'b1;
                end
                ACT_CLAIM: begin
                    if (!ready) o.status = ST_PENDING;
                    else if ((claim_tbl[r.job_slot] & node_bit) != 0) o.status = ST_CLAIMED;
                    else begin
                        claim_tbl[r.job_slot] = claim_tbl[r.job_slot] | node_bit;
                        o.granted = 1'b1;
                    end
                end
                ACT_CHECK: begin
                    if (ready) o.granted = 1'b1;
                    else o.status = ST_PENDING;
                end
                default: ;
            endcase
        end
        o.done_mask    = done_tbl[r.job_slot];
        o.claimed_mask = claim_tbl[r.job_slot];
        return o;
    endfunction

    task automatic report_mismatch(string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) $display("%0t: mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [MASK_W-1:0] got, logic [MASK_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic queue_request(logic [ACTION_W-1:0] action, int slot, int node);
        req_t r;
        r.action   = action;
        r.job_slot = SLOT_W'(slot);
        r.node     = NODE_W'(node);
        request_q.push_back(r);
    endtask

    // Mostly valid nodes on the newest job, with some stray slots and nodes
    function automatic req_t random_request();
        req_t r;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 8) r.action = ACT_NEW_JOB;
        else if (pick < 38) r.action = ACT_FINISH;
        else if (pick < 73) r.action = ACT_CLAIM;
        else r.action = ACT_CHECK;
        if (r.action == ACT_NEW_JOB) gen_head = gen_head + 1'b1;
        r.job_slot = chance(70) ? gen_head : SLOT_W'($urandom_range(SLOTS - 1));
        r.node = chance(85) ? NODE_W'($urandom_range(node_limit(), 1))
                            : NODE_W'($urandom_range((1 << NODE_W) - 1));
        return r;
    endfunction

    task automatic write_config(logic [NODE_W-1:0] nodes, logic [PREC_W-1:0] prec);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_NODE_COUNT;
        cfg_wdata <= CFG_DATA_W'(nodes);
        @(posedge aclk);
        cfg_addr  <= CFG_PRECEDENCE;
        cfg_wdata <= prec;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_nodes = nodes;
        cfg_prec  = prec;
        @(negedge aclk);
    endtask

    // Every request sent and every result back
    task automatic wait_idle();
        while (request_q.size() != 0 || s_tvalid || predicted_results.size() != 0)
            @(negedge aclk);
    endtask

    // Request driver
    always @(posedge aclk) begin : drive_requests
        req_t acc;
        req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                acc.action   = s_tdata[1:0];
                acc.job_slot = s_tdata[3:2];
                acc.node     = s_tdata[7:4];
                predicted_results.push_back(score_request(acc));
            end
            if (!s_tvalid || s_tready) begin
                if (request_q.size() != 0 && !chance(send_idle_pct)) begin
                    nxt = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {nxt.node, nxt.job_slot, nxt.action};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin : check_results
        rsp_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end else begin
                    want = predicted_results.pop_front();
                    check_field("granted", MASK_W'(m_tdata[0]), MASK_W'(want.granted));
                    check_field("status", MASK_W'(m_tdata[2:1]), MASK_W'(want.status));
                    check_field("slot_out", MASK_W'(m_tdata[4:3]), MASK_W'(want.slot_out));
                    check_field("done_mask", m_tdata[12:5], want.done_mask);
                    check_field("claimed_mask", m_tdata[20:13], want.claimed_mask);
                end
            end
            m_tready <= !chance(recv_stall_pct);
        end
    end

    initial begin : run_test
        logic [NODE_W-1:0] nodes;
        logic [PREC_W-1:0] prec;
        logic [PREC_W-1:0] chain;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        fail_count = 0;
        for (int i = 0; i < SLOTS; i++) begin
            done_tbl[i]  = '0;
            claim_tbl[i] = '0;
        end
        ring_head = '0;
        ring_live = 1'b0;
        gen_head  = '1;
        cfg_nodes = NODE_COUNT_RST;
        cfg_prec  = '0;
        send_idle_pct  = 6;
        recv_stall_pct = 65;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset configuration: untouched slots, node above the count, node zero
        queue_request(ACT_CHECK, 2, 1);
        queue_request(ACT_CLAIM, 3, 7);
        queue_request(ACT_FINISH, 1, 8);
        queue_request(ACT_CHECK, 0, 0);
        queue_request(ACT_NEW_JOB, 0, 0);
        wait_idle();

        // Chain graph over all eight nodes: node k needs node k-1
        chain = '0;
        for (int r = 0; r < NODES - 1; r++) chain[r * NODES] = 1'b1;
        write_config(NODE_W'(NODES), chain);
        queue_request(ACT_NEW_JOB, 3, 15);
        queue_request(ACT_CLAIM, 1, 3);
        queue_request(ACT_CHECK, 1, 2);
        queue_request(ACT_CLAIM, 1, 1);
        queue_request(ACT_CLAIM, 1, 1);
        queue_request(ACT_FINISH, 1, 1);
        queue_request(ACT_CHECK, 1, 2);
        queue_request(ACT_FINISH, 1, 8);
        queue_request(ACT_CLAIM, 1, 8);
        for (int k = 3; k < NODES; k++) queue_request(ACT_FINISH, 1, k);
        queue_request(ACT_CLAIM, 1, 8);
        queue_request(ACT_CHECK, 1, 15);
        queue_request(ACT_CHECK, 1, 9);
        repeat (3) queue_request(ACT_NEW_JOB, 0, 0);
        queue_request(ACT_CHECK, 0, 8);
        wait_idle();
        gen_head = ring_head;

        // Random phases, each under its own graph
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 3) begin
                send_idle_pct  = 65;
                recv_stall_pct = 6;
            end else if (phase == 6) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            prec = PREC_W'({$urandom(), $urandom()});
            case (phase)
                0: nodes = NODE_W'(NODES);
                1: begin
                    nodes = 2;
                    prec  = '1;
                end
                2: nodes = 0;
                3: nodes = '1;
                4: begin
                    nodes = 1;
                    prec  = '1;
                end
                5: begin
                    nodes = NODE_W'($urandom_range(NODES - 1, 3));
                    prec  = prec & PREC_W'({$urandom(), $urandom()});
                end
                6: begin
                    nodes = NODE_W'(NODES);
                    prec  = '0;
                end
                7: begin
                    nodes = NODE_W'($urandom_range((1 << NODE_W) - 1));
                    prec  = prec & PREC_W'({$urandom(), $urandom()});
                end
                default: nodes = NODE_W'($urandom_range((1 << NODE_W) - 1));
            endcase
            write_config(nodes, prec);
            for (int i = 0; i < PHASE_ITEMS; i++) request_q.push_back(random_request());
            wait_idle();
            gen_head = ring_head;
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("dag_task_dependency_scoreboard_tb: PASS");
        end else begin
            $display("dag_task_dependency_scoreboard_tb: FAIL");
        end
        $finish;
    end

endmodule

[dag_task_dependency_scoreboard.f]
src/dtds_pkg.sv
src/dtds_cfg.sv
src/dtds_core.sv
src/dag_task_dependency_scoreboard.sv
test/dag_task_dependency_scoreboard_tb.sv
